// ----- design/iekm_pkg.sv -----
// iekm_pkg: shared types and constants of the input event key mapper
// used by iekm_front, iekm_queue, iekm_back and input_event_key_mapper_unit
// no dependencies
package iekm_pkg;

  // field widths
  localparam int TYPE_W   = 5;
  localparam int CODE_W   = 10;
  localparam int VALUE_W  = 32;
  localparam int SLOT_W   = 4;
  localparam int KEY_W    = 10;
  localparam int KEYS_W   = 3 * KEY_W;
  localparam int STATE_W  = 2;
  localparam int LEVEL_W  = 2;
  localparam int S_DATA_W = 128;
  localparam int M_DATA_W = 32;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 15;
  localparam int COUNT_W    = 5;
  localparam int THRESH_W   = 15;

  localparam logic [CFG_IDX_W-1:0] REG_MAP_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 1'd1;
  localparam logic [THRESH_W-1:0]  THRESH_RESET  = 15'd25000;

  // action codes carried in tuser
  localparam logic ACT_EVENT = 1'b0;
  localparam logic ACT_LOAD  = 1'b1;

  // event types
  localparam logic [TYPE_W-1:0] TYPE_SYNC = 5'd0;
  localparam logic [TYPE_W-1:0] TYPE_ABS  = 5'd3;
  localparam logic [TYPE_W-1:0] TYPE_MISC = 5'd4;

  // quantized axis levels, two's complement
  localparam logic [LEVEL_W-1:0] LEVEL_CENTER = 2'b00;
  localparam logic [LEVEL_W-1:0] LEVEL_POS    = 2'b01;
  localparam logic [LEVEL_W-1:0] LEVEL_NEG    = 2'b11;

  // key states
  localparam logic [STATE_W-1:0] KEY_RELEASE = 2'd0;
  localparam logic [STATE_W-1:0] KEY_PRESS   = 2'd1;
  localparam logic [STATE_W-1:0] KEY_HOLD    = 2'd2;

  localparam logic [VALUE_W-1:0] VALUE_HOLD    = 32'd2;
  localparam logic [VALUE_W-1:0] VALUE_RELEASE = 32'd0;

  typedef struct packed {
    logic [CODE_W-1:0]  code;
    logic [VALUE_W-1:0] value;
    logic [KEYS_W-1:0]  keys;   // key a lowest
  } entry_t;

  typedef struct packed {
    logic               load;
    logic               axis;   // axis level changed, walk press/release first
    logic [LEVEL_W-1:0] level;
    logic [CODE_W-1:0]  code;
    logic [VALUE_W-1:0] value;
    logic [SLOT_W-1:0]  slot;
    entry_t             entry;
  } cmd_t;

endpackage

// ----- design/input_event_key_mapper_unit.sv -----
// input_event_key_mapper_unit: an event beat enters a two-entry queue, from which the
// table walker takes it when idle. A load is written into the table as it is taken; an
// event walks the table entries in use, reading each from the single-port table and then
// comparing it, and walks them once more first when an axis level changes. A result is
// held until the next one is found or the walk ends.
// Reset (rst, synchronous): map_count 0, threshold 25000, axes centered; table undefined
module input_event_key_mapper_unit #(
  parameter int TABLE_DEPTH = 16,
  parameter int AXIS_COUNT  = 2
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // event_type, event_code, event_value, entry_index, entry_code, entry_value,
  // entry_key_a, entry_key_b, entry_key_c, zero fill
  input  logic [iekm_pkg::S_DATA_W-1:0]       s_axis_tdata,
  // action
  input  logic                                s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // out_key_a, out_key_b, out_key_c, key_state
  output logic [iekm_pkg::M_DATA_W-1:0]       m_axis_tdata,
  output logic                                m_axis_tlast,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [iekm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [iekm_pkg::CFG_DATA_W-1:0]     cfg_data
);

  logic [iekm_pkg::COUNT_W-1:0]  map_count;
  logic [iekm_pkg::THRESH_W-1:0] analog_threshold;

  logic           fq_valid;
  logic           fq_ready;
  iekm_pkg::cmd_t fq_cmd;
  logic           qb_valid;
  logic           qb_pop;
  iekm_pkg::cmd_t qb_cmd;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      map_count        <= '0;
      analog_threshold <= iekm_pkg::THRESH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        iekm_pkg::REG_MAP_COUNT: map_count        <= cfg_data[iekm_pkg::COUNT_W-1:0];
        iekm_pkg::REG_THRESHOLD: analog_threshold <= cfg_data[iekm_pkg::THRESH_W-1:0];
        default: ;
      endcase
    end
  end

  iekm_front #(
    .AXIS_COUNT (AXIS_COUNT)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .threshold     (analog_threshold),
    .q_valid       (fq_valid),
    .q_ready       (fq_ready),
    .q_cmd         (fq_cmd)
  );

  iekm_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (fq_valid),
    .wr_ready (fq_ready),
    .wr_cmd   (fq_cmd),
    .rd_valid (qb_valid),
    .rd_pop   (qb_pop),
    .rd_cmd   (qb_cmd)
  );

  iekm_back #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (qb_valid),
    .q_pop         (qb_pop),
    .q_cmd         (qb_cmd),
    .map_count     (map_count),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

// ----- design/iekm_front.sv -----
// iekm_front: accepts input beats, drops ignored events, quantizes analog axes
// and keeps the axis levels; hands work to the queue as iekm_pkg::cmd_t
// depends on iekm_pkg
module iekm_front #(
  parameter int AXIS_COUNT = 2
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [iekm_pkg::S_DATA_W-1:0]      s_axis_tdata,
  input  logic                               s_axis_tuser,
  input  logic [iekm_pkg::THRESH_W-1:0]      threshold,
  output logic                               q_valid,
  input  logic                               q_ready,
  output iekm_pkg::cmd_t                     q_cmd
);

  localparam int XW = (AXIS_COUNT > 1) ? $clog2(AXIS_COUNT) : 1;

  logic [iekm_pkg::LEVEL_W-1:0] axis_level [AXIS_COUNT];

  logic [iekm_pkg::TYPE_W-1:0]  ev_type;
  logic [iekm_pkg::CODE_W-1:0]  ev_code;
  logic [iekm_pkg::VALUE_W-1:0] ev_value;
  logic                         is_load;
  logic                         ignored;
  logic                         on_axis;
  logic [iekm_pkg::LEVEL_W-1:0] level;
  logic [iekm_pkg::LEVEL_W-1:0] cur_level;
  logic                         drop;
  logic                         accept;
  logic signed [31:0]           thr_pos;

  assign ev_type  = s_axis_tdata[4:0];
  assign ev_code  = s_axis_tdata[14:5];
  assign ev_value = s_axis_tdata[46:15];

  assign is_load = (s_axis_tuser == iekm_pkg::ACT_LOAD);
  assign ignored = (ev_type == iekm_pkg::TYPE_SYNC) || (ev_type == iekm_pkg::TYPE_MISC);
  assign on_axis = (ev_type == iekm_pkg::TYPE_ABS) && (32'(ev_code) < 32'(AXIS_COUNT));
  assign thr_pos = $signed(32'(threshold));

  always_comb begin
    if ($signed(ev_value) > thr_pos) begin
      level = iekm_pkg::LEVEL_POS;
    end else if ($signed(ev_value) < -thr_pos) begin
      level = iekm_pkg::LEVEL_NEG;
    end else begin
      level = iekm_pkg::LEVEL_CENTER;
    end
  end

  // only meaningful when on_axis
  assign cur_level = axis_level[ev_code[XW-1:0]];

  assign drop = !is_load && (ignored || (on_axis && (level == cur_level)));

  assign s_axis_tready = q_ready;
  assign q_valid       = s_axis_tvalid && !drop;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    q_cmd             = '0;
    q_cmd.load        = is_load;
    q_cmd.axis        = on_axis;
    q_cmd.level       = level;
    q_cmd.code        = ev_code;
    q_cmd.value       = ev_value;
    q_cmd.slot        = s_axis_tdata[50:47];
    q_cmd.entry.code  = s_axis_tdata[60:51];
    q_cmd.entry.value = s_axis_tdata[92:61];
    q_cmd.entry.keys  = s_axis_tdata[122:93];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < AXIS_COUNT; i++) begin
        axis_level[i] <= iekm_pkg::LEVEL_CENTER;
      end
    end else if (accept && !is_load && !ignored && on_axis && (level != cur_level)) begin
      axis_level[ev_code[XW-1:0]] <= level;
    end
  end

endmodule

// ----- design/iekm_queue.sv -----
// iekm_queue: two-entry command queue between front and back
// depends on iekm_pkg
module iekm_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_valid,
  output logic            wr_ready,
  input  iekm_pkg::cmd_t  wr_cmd,
  output logic            rd_valid,
  input  logic            rd_pop,
  output iekm_pkg::cmd_t  rd_cmd
);

  iekm_pkg::cmd_t slots [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     fill;
  logic           push;
  logic           pop;

  assign wr_ready = (fill != 2'd2);
  assign rd_valid = (fill != 2'd0);
  assign rd_cmd   = slots[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_pop && rd_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

// ----- design/iekm_back.sv -----
// iekm_back: holds the mapping table, walks it for each event command and
// drives the result beats; one result is held back so the final one gets tlast
// depends on iekm_pkg
module iekm_back #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              q_valid,
  output logic                              q_pop,
  input  iekm_pkg::cmd_t                    q_cmd,
  input  logic [iekm_pkg::COUNT_W-1:0]      map_count,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [iekm_pkg::M_DATA_W-1:0]     m_axis_tdata,
  output logic                              m_axis_tlast
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_READ  = 3'd1;
  localparam logic [2:0] S_CMP   = 3'd2;
  localparam logic [2:0] S_EMIT  = 3'd3;
  localparam logic [2:0] S_FLUSH = 3'd4;

  iekm_pkg::entry_t mem [TABLE_DEPTH];
  iekm_pkg::entry_t rd_entry;
  iekm_pkg::cmd_t   cur;

  logic [2:0]                      state;
  logic [CW-1:0]                   idx;
  logic [CW-1:0]                   cnt;
  logic [CW-1:0]                   cnt_sat;
  logic                            axis_phase;
  logic [iekm_pkg::KEYS_W-1:0]     emit_keys;
  logic [iekm_pkg::STATE_W-1:0]    emit_st;
  logic                            emit_rel;
  logic                            held_valid;
  logic [iekm_pkg::KEYS_W-1:0]     held_keys;
  logic [iekm_pkg::STATE_W-1:0]    held_st;
  logic [iekm_pkg::KEYS_W-1:0]     out_keys;
  logic [iekm_pkg::STATE_W-1:0]    out_st;
  logic                            out_last;
  logic                            out_free;
  logic                            can_deliver;
  logic                            push_out;
  logic [AW+3:0]                   slot_w;
  logic [iekm_pkg::VALUE_W-1:0]    want_value;
  logic                            hit;
  logic [iekm_pkg::STATE_W-1:0]    raw_st;

  assign out_free    = !m_axis_tvalid || m_axis_tready;
  assign can_deliver = !held_valid || out_free;
  assign q_pop       = (state == S_IDLE) && q_valid;
  assign slot_w      = (AW + 4)'(q_cmd.slot);

  // held result moves to the output register
  assign push_out = held_valid && out_free && ((state == S_EMIT) || (state == S_FLUSH));

  assign cnt_sat = (32'(map_count) > 32'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : CW'(map_count);

  // axis walk compares against the sign-extended level
  assign want_value = axis_phase ? {{(iekm_pkg::VALUE_W - 1){cur.level[1]}}, cur.level[0]}
                                 : cur.value;
  assign hit = (rd_entry.code == cur.code) && (rd_entry.value == want_value);

  always_comb begin
    if (rd_entry.value == iekm_pkg::VALUE_HOLD) begin
      raw_st = iekm_pkg::KEY_HOLD;
    end else if (rd_entry.value == iekm_pkg::VALUE_RELEASE) begin
      raw_st = iekm_pkg::KEY_RELEASE;
    end else begin
      raw_st = iekm_pkg::KEY_PRESS;
    end
  end

  // table memory
  always_ff @(posedge clk) begin
    if (q_pop && q_cmd.load && (slot_w < (AW + 4)'(TABLE_DEPTH))) begin
      mem[slot_w[AW-1:0]] <= q_cmd.entry;
    end
    if ((state == S_READ) && (idx < cnt)) begin
      rd_entry <= mem[idx[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      idx           <= '0;
      cnt           <= '0;
      axis_phase    <= 1'b0;
      emit_rel      <= 1'b0;
      held_valid    <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (push_out) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (q_valid && !q_cmd.load) begin
            idx        <= '0;
            cnt        <= cnt_sat;
            axis_phase <= q_cmd.axis;
            state      <= S_READ;
          end
        end
        S_READ: begin
          if (idx < cnt) begin
            state <= S_CMP;
          end else if (axis_phase) begin
            axis_phase <= 1'b0;
            idx        <= '0;
          end else begin
            state <= S_FLUSH;
          end
        end
        S_CMP: begin
          if (hit) begin
            emit_keys <= rd_entry.keys;
            emit_st   <= axis_phase ? iekm_pkg::KEY_PRESS : raw_st;
            emit_rel  <= axis_phase;
            state     <= S_EMIT;
          end else begin
            idx   <= idx + CW'(1);
            state <= S_READ;
          end
        end
        S_EMIT: begin
          if (can_deliver) begin
            // older held result leaves, not last
            if (held_valid) begin
              out_keys <= held_keys;
              out_st   <= held_st;
              out_last <= 1'b0;
            end
            held_valid <= 1'b1;
            held_keys  <= emit_keys;
            held_st    <= emit_st;
            if (emit_rel) begin
              emit_st  <= iekm_pkg::KEY_RELEASE;
              emit_rel <= 1'b0;
            end else begin
              idx   <= idx + CW'(1);
              state <= S_READ;
            end
          end
        end
        S_FLUSH: begin
          if (!held_valid) begin
            state <= S_IDLE;
          end else if (out_free) begin
            out_keys   <= held_keys;
            out_st     <= held_st;
            out_last   <= 1'b1;
            held_valid <= 1'b0;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tdata = {out_st, out_keys};
  assign m_axis_tlast = out_last;

`ifndef SYNTHESIS
  a_idle_no_held: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !held_valid)
    else $error("held result left behind at idle");

  a_cmp_next: assert property (@(posedge clk) disable iff (rst)
    (state == S_CMP) |=> ((state == S_READ) || (state == S_EMIT)))
    else $error("bad step after compare");

  a_idx_bound: assert property (@(posedge clk) disable iff (rst)
    ((state == S_CMP) || (state == S_EMIT)) |-> (idx < cnt))
    else $error("walk index past table count");

  a_emit_pushes: assert property (@(posedge clk) disable iff (rst)
    ((state == S_EMIT) && held_valid && out_free) |=> m_axis_tvalid)
    else $error("held result not pushed to output");
`endif

endmodule

// ----- sim/input_event_key_mapper_unit_tb.sv -----
// input_event_key_mapper_unit_tb: self-checking bench for the event key mapper unit
// loads mapping tables, sends events, predicts every key beat and checks them in order
// depends on iekm_pkg and input_event_key_mapper_unit
module input_event_key_mapper_unit_tb;

  localparam int DEPTH = 16;
  localparam int AXES = 2;
  localparam int SETTLE_CYCLES = 300;
  localparam int HOLDOFF_CYCLES = 500;

  typedef logic [iekm_pkg::TYPE_W-1:0]         type_t;
  typedef logic [iekm_pkg::CODE_W-1:0]         code_t;
  typedef logic signed [iekm_pkg::VALUE_W-1:0] value_t;
  typedef logic [iekm_pkg::SLOT_W-1:0]         slot_t;
  typedef logic [iekm_pkg::KEYS_W-1:0]         keys_t;
  typedef logic [iekm_pkg::STATE_W-1:0]        state_t;

  // ordinary event types, compared like any other
  localparam type_t TYPE_KEY = 5'd1;
  localparam type_t TYPE_REL = 5'd2;

  localparam value_t VALUE_MIN = 32'sh8000_0000;
  localparam value_t VALUE_MAX = 32'sh7FFF_FFFF;

  typedef struct {
    logic   act;
    type_t  ev_type;
    code_t  ev_code;
    value_t ev_value;
    slot_t  slot;
    code_t  ent_code;
    value_t ent_value;
    keys_t  ent_keys;
  } input_beat_t;

  typedef struct {
    keys_t  keys;
    state_t state;
    logic   last;
  } key_beat_t;

  logic                                clk = 1'b0;
  logic                                rst = 1'b1;
  logic                                s_axis_tvalid = 1'b0;
  logic                                s_axis_tready;
  logic [iekm_pkg::S_DATA_W-1:0]       s_axis_tdata = '0;
  logic                                s_axis_tuser = 1'b0;
  logic                                m_axis_tvalid;
  logic                                m_axis_tready = 1'b0;
  logic [iekm_pkg::M_DATA_W-1:0]       m_axis_tdata;
  logic                                m_axis_tlast;
  logic                                cfg_valid = 1'b0;
  logic                                cfg_ready;
  logic [iekm_pkg::CFG_IDX_W-1:0]      cfg_index = '0;
  logic [iekm_pkg::CFG_DATA_W-1:0]     cfg_data = '0;

  input_event_key_mapper_unit #(
    .TABLE_DEPTH(DEPTH),
    .AXIS_COUNT (AXES)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // mirror of the mapper state
  code_t       tbl_code [DEPTH];
  value_t      tbl_value [DEPTH];
  keys_t       tbl_keys [DEPTH];
  int          axis_lvl [AXES];
  int unsigned map_cnt = 0;
  int unsigned thresh = 32'(iekm_pkg::THRESH_RESET);

  input_beat_t pending_inputs[$];
  key_beat_t   key_beats_due[$];
  input_beat_t driven;
  logic        beat_taken = 1'b0;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int holdoff_req = 0;
  int holdoff_seen = 0;
  int holdoff_left = 0;

  int errors = 0;
  int loads_in = 0;
  int events_in = 0;
  int beats_out = 0;
  int cfg_writes = 0;
  int longest_burst = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #20000000;
    $display("input_event_key_mapper_unit_tb: done, errors");
    $finish;
  end

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    $display("%0t: %s mismatch, got %0h, expected %0h", $time, what, got, want);
    errors++;
  endtask

  function automatic key_beat_t make_key_beat(input keys_t keys, input state_t st);
    key_beat_t kb;
    kb.keys = keys;
    kb.state = st;
    kb.last = 1'b0;
    return kb;
  endfunction

  // predicts the key beats caused by one accepted input beat
  task automatic map_input(input input_beat_t b);
    key_beat_t   burst[$];
    int unsigned used;
    int          thr;
    int          lvl;
    state_t      st;
    if (b.act == iekm_pkg::ACT_LOAD) begin
      tbl_code[b.slot] = b.ent_code;
      tbl_value[b.slot] = b.ent_value;
      tbl_keys[b.slot] = b.ent_keys;
      loads_in++;
      return;
    end
    events_in++;
    if (b.ev_type == iekm_pkg::TYPE_SYNC || b.ev_type == iekm_pkg::TYPE_MISC) return;
    used = map_cnt > DEPTH ? DEPTH : map_cnt;
    if (b.ev_type == iekm_pkg::TYPE_ABS && b.ev_code < AXES) begin
      thr = thresh;
      if (b.ev_value > thr) lvl = 1;
      else if (b.ev_value < -thr) lvl = -1;
      else lvl = 0;
      // an unchanged level ends the event here
      if (axis_lvl[b.ev_code] == lvl) return;
      axis_lvl[b.ev_code] = lvl;
      for (int i = 0; i < used; i++) begin
        if (tbl_code[i] == b.ev_code && tbl_value[i] == lvl) begin
          burst.push_back(make_key_beat(tbl_keys[i], iekm_pkg::KEY_PRESS));
          burst.push_back(make_key_beat(tbl_keys[i], iekm_pkg::KEY_RELEASE));
        end
      end
    end
    for (int i = 0; i < used; i++) begin
      if (tbl_code[i] == b.ev_code && tbl_value[i] == b.ev_value) begin
        if (tbl_value[i] == iekm_pkg::VALUE_HOLD) st = iekm_pkg::KEY_HOLD;
        else if (tbl_value[i] == iekm_pkg::VALUE_RELEASE) st = iekm_pkg::KEY_RELEASE;
        else st = iekm_pkg::KEY_PRESS;
        burst.push_back(make_key_beat(tbl_keys[i], st));
      end
    end
    if (burst.size() > 0) begin
      burst[burst.size()-1].last = 1'b1;
      if (burst.size() > longest_burst) longest_burst = burst.size();
    end
    foreach (burst[i]) key_beats_due.push_back(burst[i]);
  endtask

  // sender: holds a beat until taken, otherwise offers the next one or idles
  always @(negedge clk) begin
    logic offer;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || beat_taken) begin
      beat_taken = 1'b0;
      offer = pending_inputs.size() > 0 && $urandom_range(99) >= send_idle_pct;
      if (offer) begin
        driven = pending_inputs.pop_front();
        s_axis_tdata <= {5'b0, driven.ent_keys, driven.ent_value, driven.ent_code,
                         driven.slot, driven.ev_value, driven.ev_code, driven.ev_type};
        s_axis_tuser <= driven.act;
      end
      s_axis_tvalid <= offer;
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(negedge clk) begin
    if (holdoff_req != holdoff_seen) begin
      holdoff_seen = holdoff_req;
      holdoff_left = HOLDOFF_CYCLES;
    end
    if (holdoff_left > 0) begin
      holdoff_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= $urandom_range(99) >= recv_stall_pct;
    end
  end

  always @(posedge clk) begin
    key_beat_t want;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        beats_out++;
        if (key_beats_due.size() == 0) begin
          flag_mismatch("unexpected beat", m_axis_tdata, 32'd0);
        end else begin
          want = key_beats_due.pop_front();
          if (m_axis_tdata[iekm_pkg::KEY_W-1:0] !== want.keys[iekm_pkg::KEY_W-1:0])
            flag_mismatch("key a", 32'(m_axis_tdata[iekm_pkg::KEY_W-1:0]),
                          32'(want.keys[iekm_pkg::KEY_W-1:0]));
          if (m_axis_tdata[2*iekm_pkg::KEY_W-1:iekm_pkg::KEY_W] !==
              want.keys[2*iekm_pkg::KEY_W-1:iekm_pkg::KEY_W])
            flag_mismatch("key b", 32'(m_axis_tdata[2*iekm_pkg::KEY_W-1:iekm_pkg::KEY_W]),
                          32'(want.keys[2*iekm_pkg::KEY_W-1:iekm_pkg::KEY_W]));
          if (m_axis_tdata[iekm_pkg::KEYS_W-1:2*iekm_pkg::KEY_W] !==
              want.keys[iekm_pkg::KEYS_W-1:2*iekm_pkg::KEY_W])
            flag_mismatch("key c", 32'(m_axis_tdata[iekm_pkg::KEYS_W-1:2*iekm_pkg::KEY_W]),
                          32'(want.keys[iekm_pkg::KEYS_W-1:2*iekm_pkg::KEY_W]));
          if (m_axis_tdata[iekm_pkg::M_DATA_W-1:iekm_pkg::KEYS_W] !== want.state)
            flag_mismatch("key state",
                          32'(m_axis_tdata[iekm_pkg::M_DATA_W-1:iekm_pkg::KEYS_W]),
                          32'(want.state));
          if (m_axis_tlast !== want.last)
            flag_mismatch("tlast", 32'(m_axis_tlast), 32'(want.last));
        end
      end
      if (cfg_valid && cfg_ready) begin
        cfg_writes++;
        if (cfg_index == iekm_pkg::REG_MAP_COUNT)
          map_cnt = 32'(cfg_data[iekm_pkg::COUNT_W-1:0]);
        else if (cfg_index == iekm_pkg::REG_THRESHOLD)
          thresh = 32'(cfg_data[iekm_pkg::THRESH_W-1:0]);
      end
      if (s_axis_tvalid && s_axis_tready) begin
        beat_taken = 1'b1;
        map_input(driven);
      end
    end
  end

  task automatic write_reg(input logic [iekm_pkg::CFG_IDX_W-1:0] idx,
                           input int unsigned val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[iekm_pkg::CFG_DATA_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // waits until every beat is taken and answered, then lets silent work finish
  task automatic drain();
    do @(posedge clk);
    while (pending_inputs.size() != 0 || s_axis_tvalid || key_beats_due.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_idle(input int mode);
    case (mode)
      0: begin send_idle_pct = 0; recv_stall_pct = 0; end
      1: begin send_idle_pct = 76; recv_stall_pct = 0; end
      2: begin send_idle_pct = 0; recv_stall_pct = 76; end
      default: begin send_idle_pct = 22; recv_stall_pct = 22; end
    endcase
  endtask

  task automatic queue_load(input int slot, input code_t code, input value_t value,
                            input keys_t keys);
    input_beat_t b;
    b.act = iekm_pkg::ACT_LOAD;
    b.ev_type = type_t'($urandom);
    b.ev_code = code_t'($urandom);
    b.ev_value = $urandom;
    b.slot = slot_t'(slot);
    b.ent_code = code;
    b.ent_value = value;
    b.ent_keys = keys;
    pending_inputs.push_back(b);
  endtask

  task automatic queue_event(input type_t etype, input code_t code, input value_t value);
    input_beat_t b;
    b.act = iekm_pkg::ACT_EVENT;
    b.ev_type = etype;
    b.ev_code = code;
    b.ev_value = value;
    b.slot = slot_t'($urandom);
    b.ent_code = code_t'($urandom);
    b.ent_value = $urandom;
    b.ent_keys = keys_t'($urandom);
    pending_inputs.push_back(b);
  endtask

  // codes cluster on a few values so that table hits are frequent
  function automatic code_t pick_code();
    case ($urandom_range(9))
      0, 1, 2: return 0;
      3, 4:    return 1;
      5:       return 2;
      6:       return 5;
      default: return code_t'($urandom);
    endcase
  endfunction

  function automatic value_t pick_match_value();
    case ($urandom_range(7))
      0:       return -1;
      1:       return 0;
      2:       return 1;
      3:       return 2;
      4:       return $urandom_range(9);
      5:       return -int'($urandom_range(9));
      default: return $urandom;
    endcase
  endfunction

  function automatic value_t pick_axis_value();
    int thr;
    thr = thresh;
    case ($urandom_range(7))
      0:       return thr;
      1:       return thr + 1;
      2:       return -thr;
      3:       return -thr - 1;
      4:       return 0;
      5:       return thr + int'($urandom_range(1000));
      6:       return -thr - int'($urandom_range(1000));
      default: return $urandom;
    endcase
  endfunction

  task automatic random_items(input int n);
    type_t etype;
    code_t code;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(99) < 12) begin
        queue_load($urandom_range(DEPTH-1), pick_code(), pick_match_value(),
                   keys_t'($urandom));
      end else begin
        case ($urandom_range(19))
          0, 1, 2, 3, 4, 5, 6, 7: etype = iekm_pkg::TYPE_ABS;
          8, 9, 10, 11, 12, 13:   etype = TYPE_KEY;
          14:                     etype = TYPE_REL;
          15, 16, 17:             etype = type_t'($urandom);
          18:                     etype = iekm_pkg::TYPE_SYNC;
          default:                etype = iekm_pkg::TYPE_MISC;
        endcase
        if (etype == iekm_pkg::TYPE_ABS && $urandom_range(9) < 8)
          code = code_t'($urandom_range(AXES-1));
        else code = pick_code();
        if (etype == iekm_pkg::TYPE_ABS && code < AXES)
          queue_event(etype, code, pick_axis_value());
        else queue_event(etype, code, pick_match_value());
      end
    end
  endtask

  initial begin
    int unsigned run_counts [5];
    int unsigned run_thresh [5];
    foreach (tbl_code[i]) begin
      tbl_code[i] = '0;
      tbl_value[i] = '0;
      tbl_keys[i] = '0;
    end
    foreach (axis_lvl[i]) axis_lvl[i] = 0;
    run_counts = '{16, 6, 1, 16, 11};
    run_thresh = '{25000, 0, 1000, 32767, $urandom_range(32767)};

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    set_idle(0);

    // no slots in use yet: events only move the axis levels
    write_reg(iekm_pkg::REG_MAP_COUNT, 0);
    queue_event(iekm_pkg::TYPE_ABS, 0, 30000);
    queue_event(TYPE_KEY, 5, 2);
    queue_load(0, 0, 1, keys_t'($urandom));
    queue_load(1, 0, -1, keys_t'($urandom));
    queue_load(2, 1, 1, keys_t'($urandom));
    queue_load(3, 1, -1, keys_t'($urandom));
    queue_load(4, 5, 2, keys_t'($urandom));
    queue_load(5, 5, 0, keys_t'($urandom));
    queue_load(6, 5, 7, keys_t'($urandom));
    queue_load(7, 1023, VALUE_MIN, 30'h3FFF_FFFF);
    queue_load(8, 1023, VALUE_MAX, 30'h0);
    queue_load(9, 0, 0, keys_t'($urandom));
    queue_load(10, 2, 1, keys_t'($urandom));
    queue_load(11, 5, 2, keys_t'($urandom));
    for (int i = 12; i < DEPTH; i++)
      queue_load(i, code_t'(700 + i), $urandom, keys_t'($urandom));
    drain();

    write_reg(iekm_pkg::REG_MAP_COUNT, DEPTH);
    write_reg(iekm_pkg::REG_THRESHOLD, 25000);
    queue_event(iekm_pkg::TYPE_ABS, 0, -30000);
    queue_event(iekm_pkg::TYPE_ABS, 0, -25001);   // level unchanged
    queue_event(iekm_pkg::TYPE_ABS, 0, 0);        // back to center, press/release then release
    queue_event(iekm_pkg::TYPE_ABS, 1, 25001);
    queue_event(iekm_pkg::TYPE_ABS, 1, 25000);    // at threshold counts as centered
    queue_event(iekm_pkg::TYPE_ABS, 2, 1);        // axis out of range goes to raw matching
    queue_event(TYPE_KEY, 5, 2);
    queue_event(TYPE_KEY, 5, 0);
    queue_event(TYPE_KEY, 5, 7);
    queue_event(5'd31, 1023, VALUE_MIN);
    queue_event(TYPE_REL, 1023, VALUE_MAX);
    queue_event(iekm_pkg::TYPE_SYNC, 5, 2);
    queue_event(iekm_pkg::TYPE_MISC, 5, 2);
    queue_event(iekm_pkg::TYPE_ABS, 1023, VALUE_MAX);
    queue_load(15, 5, 2, keys_t'($urandom));
    queue_event(TYPE_KEY, 5, 2);
    drain();

    // every slot on one code and level: a single axis step yields the longest burst
    write_reg(iekm_pkg::REG_THRESHOLD, 0);
    for (int i = 0; i < DEPTH; i++) queue_load(i, 0, 1, keys_t'($urandom));
    queue_event(iekm_pkg::TYPE_ABS, 0, 1);
    queue_event(iekm_pkg::TYPE_ABS, 0, -1);
    drain();

    // count beyond the table depth saturates
    write_reg(iekm_pkg::REG_MAP_COUNT, 20);
    write_reg(iekm_pkg::REG_THRESHOLD, 32767);
    queue_event(TYPE_KEY, 0, 1);
    queue_event(iekm_pkg::TYPE_ABS, 0, 32767);
    queue_event(iekm_pkg::TYPE_ABS, 0, 32768);
    drain();

    for (int phase = 0; phase < 5; phase++) begin
      write_reg(iekm_pkg::REG_MAP_COUNT, run_counts[phase]);
      write_reg(iekm_pkg::REG_THRESHOLD, run_thresh[phase]);
      set_idle(phase % 4);
      if (phase == 0) begin
        for (int i = 0; i < DEPTH; i++)
          queue_load(i, pick_code(), pick_match_value(), keys_t'($urandom));
        // long receiver hold-off while the sender keeps pushing
        holdoff_req++;
      end
      random_items(35);
      if (phase == 2) drain();
      random_items(35);
      drain();
    end

    $display("covered %0d loads and %0d events over several table, count, threshold",
             loads_in, events_in);
    $display("and idling settings; %0d key beats checked, longest burst %0d, %0d reg writes",
             beats_out, longest_burst, cfg_writes);
    if (errors == 0) begin
      $display("input_event_key_mapper_unit_tb: done, clean");
    end else begin
      $display("input_event_key_mapper_unit_tb: done, errors");
    end
    $finish;
  end

endmodule
